/* hw/rtl/brah_pkg.sv */
// Shared types and constants for the binned rate averager history unit.
package brah_pkg;

    localparam int MAX_CH     = 10;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 40;
    localparam int SUM_W      = 64;
    localparam int RES_W      = 20;
    localparam int WIN_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int DATA_W     = TIME_W + MAX_CH * RATE_W;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = SUM_W / DIV_BITS;

    localparam logic [RES_W-1:0] RESOLUTION_RST = RES_W'(1000);
    localparam logic [WIN_W-1:0] WINDOW_RST     = WIN_W'(300000);
    localparam logic [RES_W-1:0] REFRESH_RST    = RES_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESOLUTION = 2'd0,
        REG_MAX_WINDOW = 2'd1,
        REG_REFRESH    = 2'd2
    } cfg_reg_t;

    typedef logic [RATE_W-1:0] rate_t;
    typedef logic [SUM_W-1:0]  sum_t;

endpackage

/* hw/rtl/binned_rate_averager_history_unit.sv */
// Top level: per-channel rate averaging into a duration-tagged history ring.
//
// Usage: each input beat on s_* carries a millisecond timestamp and one rate
// sample for ten channels. Every accepted beat yields exactly one result beat
// on m_*: m_tuser flags a closed bin, m_tdata carries the held window duration
// and, for a closed bin, the ten truncated averages (zero otherwise).
// Registers are written through cfg_* while the unit is idle.
// Per-channel sums live in a small RAM with a registered read, the bin durations
// and bin averages in history RAMs with a ring head and fill count.
// Steps: a beat that closes no bin runs a read and an add state per channel,
// then the done state that loads the result; s_tready returns in the cycle the
// result appears. A closing beat first walks out, past the window, the oldest
// bins (a read and a check per evicted bin), then runs a ring check (plus a drop
// of the oldest bin when full), an append and, per channel, a read, an add and
// the divider (64/32 restoring, 4 quotient bits a cycle).
// One beat is in work at a time; s_tready is high only between beats.
// The result sits in an output register, so a new beat is taken while a
// stalled result waits; a finished beat then holds until the register frees.
// Reset (aresetn low, synchronous) clears sums, counters, ring pointers and
// registers to defaults; history RAM contents are left as they are.
module binned_rate_averager_history_unit #(
    parameter int NUM_CHANNELS  = 10,
    parameter int HISTORY_DEPTH = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beat
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: now_ms, rate_ch0 .. rate_ch9
    input  logic [brah_pkg::DATA_W-1:0]       s_tdata,
    // result beat
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: window_ms, avg_ch0 .. avg_ch9
    output logic [brah_pkg::DATA_W-1:0]       m_tdata,
    // tuser: bin_flushed
    output logic                              m_tuser,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brah_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brah_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import brah_pkg::*;

    localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int VD  = HISTORY_DEPTH * NUM_CHANNELS;
    localparam int VAW = $clog2(VD);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_EV_RD    = 10'b0000000010,
        ST_EV_CHK   = 10'b0000000100,
        ST_FULL     = 10'b0000001000,
        ST_FULL_DRP = 10'b0000010000,
        ST_APPEND   = 10'b0000100000,
        ST_CH_RD    = 10'b0001000000,
        ST_CH_ADD   = 10'b0010000000,
        ST_CH_DIV   = 10'b0100000000,
        ST_DONE     = 10'b1000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [RES_W-1:0] res_reg;
    logic [WIN_W-1:0] win_reg;
    logic [RES_W-1:0] refr_reg;

    // scalar state
    logic [TIME_W-1:0] cnt_reg;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] held_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     ring_cnt_reg;

    // per-beat working registers
    rate_t             in_reg [MAX_CH];
    rate_t             avg_reg [MAX_CH];
    logic              flush_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] divisor_reg;
    logic [CHW-1:0]    ch_reg;
    logic [VAW-1:0]    base_reg;

    // divider
    sum_t              quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [3:0]        step_reg;

    // memories
    sum_t                   sum_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] sum_vld_reg;
    sum_t                   sum_rd_reg;
    logic [TIME_W-1:0]      dur_mem [HISTORY_DEPTH];
    logic [TIME_W-1:0]      dur_rd_reg;
    rate_t                  val_mem [VD];

    // output register
    logic                   m_valid_reg;
    logic [DATA_W-1:0]      m_data_reg;
    logic                   m_user_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // elapsed-time clamp for the incoming beat
    logic [RES_W:0]    upd;
    logic [RES_W:0]    max_el;
    logic [TIME_W-1:0] el_raw;
    logic [TIME_W-1:0] el_clamp;
    logic              flush_now;
    logic [TIME_W-1:0] cnt_inc;
    logic [TIME_W-1:0] held_add;

    always_comb begin
        upd       = {1'b0, refr_reg} + (RES_W+1)'(refr_reg >> 2);
        max_el    = (upd > {1'b0, res_reg}) ? upd : {1'b0, res_reg};
        el_raw    = s_tdata[TIME_W-1:0] - last_reg;
        el_clamp  = (el_raw > TIME_W'(max_el)) ? TIME_W'(max_el) : el_raw;
        flush_now = (el_clamp >= TIME_W'(res_reg));
        cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        held_add  = held_reg + el_clamp;
    end

    // saturating channel add
    sum_t            sum_cur;
    logic [SUM_W:0]  sum_wide;
    sum_t            sum_sat;

    always_comb begin
        sum_cur  = sum_vld_reg[ch_reg] ? sum_rd_reg : '0;
        sum_wide = {1'b0, sum_cur} + (SUM_W+1)'(in_reg[ch_reg]);
        sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end

    // divider: four restoring steps per cycle
    sum_t              quo_next;
    logic [TIME_W-1:0] rem_next;
    logic [TIME_W:0]   rem_sh;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        rem_sh   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            rem_sh   = {rem_next, quo_next[SUM_W-1]};
            quo_next = {quo_next[SUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, divisor_reg}) begin
                rem_sh      = rem_sh - {1'b0, divisor_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = rem_sh[TIME_W-1:0];
        end
    end

    // ring helpers
    logic [AW-1:0]    head_inc;
    logic [TIME_W-1:0] held_drop;
    logic [AW:0]      slot_sum;
    logic [AW-1:0]    slot;
    logic [TIME_W:0]  ev_limit;
    logic             last_ch;

    always_comb begin
        head_inc  = (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        held_drop = (dur_rd_reg <= held_reg) ? held_reg - dur_rd_reg : '0;
        slot_sum  = (AW+1)'(head_reg) + (AW+1)'(ring_cnt_reg);
        slot      = (slot_sum >= (AW+1)'(HISTORY_DEPTH))
                    ? AW'(slot_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(slot_sum);
        ev_limit  = {1'b0, dur_rd_reg} + (TIME_W+1)'(win_reg);
        last_ch   = (ch_reg == CHW'(NUM_CHANNELS - 1));
    end

    // memory ports
    always_ff @(posedge aclk) begin
        sum_rd_reg <= sum_mem[ch_reg];
        dur_rd_reg <= dur_mem[head_reg];
        if (state_reg == ST_CH_ADD) begin
            sum_mem[ch_reg] <= flush_reg ? '0 : sum_sat;
        end
        if (state_reg == ST_APPEND) begin
            dur_mem[slot] <= elapsed_reg;
        end
        if (state_reg == ST_CH_DIV && step_reg == 4'(DIV_STEPS - 1)) begin
            val_mem[base_reg + VAW'(ch_reg)] <= quo_next[RATE_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int c = 0; c < MAX_CH; c++) begin
                in_reg[c]  <= s_tdata[TIME_W + c*RATE_W +: RATE_W];
                avg_reg[c] <= '0;
            end
            elapsed_reg <= el_clamp;
            divisor_reg <= cnt_inc;
        end
        if (state_reg == ST_APPEND) begin
            base_reg <= VAW'(slot) * VAW'(NUM_CHANNELS);
        end
        if (state_reg == ST_CH_ADD) begin
            quo_reg  <= sum_sat;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_CH_DIV) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
            if (step_reg == 4'(DIV_STEPS - 1)) begin
                avg_reg[ch_reg] <= quo_next[RATE_W-1:0];
            end
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg[TIME_W-1:0] <= held_reg;
            for (int c = 0; c < MAX_CH; c++) begin
                m_data_reg[TIME_W + c*RATE_W +: RATE_W] <= avg_reg[c];
            end
            m_user_reg <= flush_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            res_reg      <= RESOLUTION_RST;
            win_reg      <= WINDOW_RST;
            refr_reg     <= REFRESH_RST;
            cnt_reg      <= '0;
            last_reg     <= '0;
            held_reg     <= '0;
            head_reg     <= '0;
            ring_cnt_reg <= '0;
            sum_vld_reg  <= '0;
            flush_reg    <= 1'b0;
            ch_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drop the result beat once taken, unless a new one loads now
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RESOLUTION: res_reg  <= cfg_data[RES_W-1:0];
                    REG_MAX_WINDOW: win_reg  <= cfg_data[WIN_W-1:0];
                    REG_REFRESH:    refr_reg <= cfg_data[RES_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        flush_reg <= flush_now;
                        ch_reg    <= '0;
                        if (flush_now) begin
                            cnt_reg  <= '0;
                            last_reg <= s_tdata[TIME_W-1:0];
                            held_reg <= held_add;
                            state_reg <= (held_add > TIME_W'(win_reg)) ? ST_EV_RD : ST_FULL;
                        end else begin
                            cnt_reg   <= cnt_inc;
                            state_reg <= ST_CH_RD;
                        end
                    end
                end
                // walk the oldest bins out while the window stays covered
                ST_EV_RD: begin
                    state_reg <= (ring_cnt_reg == '0) ? ST_FULL : ST_EV_CHK;
                end
                ST_EV_CHK: begin
                    if ({1'b0, held_reg} < ev_limit) begin
                        state_reg <= ST_FULL;
                    end else begin
                        held_reg     <= held_drop;
                        head_reg     <= head_inc;
                        ring_cnt_reg <= ring_cnt_reg - 1'b1;
                        state_reg    <= ST_EV_RD;
                    end
                end
                ST_FULL: begin
                    state_reg <= (ring_cnt_reg == CW'(HISTORY_DEPTH)) ? ST_FULL_DRP : ST_APPEND;
                end
                ST_FULL_DRP: begin
                    held_reg     <= held_drop;
                    head_reg     <= head_inc;
                    ring_cnt_reg <= ring_cnt_reg - 1'b1;
                    state_reg    <= ST_APPEND;
                end
                ST_APPEND: begin
                    ring_cnt_reg <= ring_cnt_reg + 1'b1;
                    state_reg    <= ST_CH_RD;
                end
                // per-channel read, add, write back
                ST_CH_RD: begin
                    state_reg <= ST_CH_ADD;
                end
                ST_CH_ADD: begin
                    sum_vld_reg[ch_reg] <= 1'b1;
                    if (flush_reg) begin
                        state_reg <= ST_CH_DIV;
                    end else if (last_ch) begin
                        state_reg <= ST_DONE;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_CH_RD;
                    end
                end
                ST_CH_DIV: begin
                    if (step_reg == 4'(DIV_STEPS - 1)) begin
                        if (last_ch) begin
                            state_reg <= ST_DONE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_CH_RD;
                        end
                    end
                end
                // hold until the output register frees
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ring fill never exceeds the history depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        ring_cnt_reg <= CW'(HISTORY_DEPTH))
        else $error("ring fill count above depth");

    // one beat in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while previous beat in work");

    // a result without a closed bin carries zero averages
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[DATA_W-1:TIME_W] == '0))
        else $error("averages set on a beat that closed no bin");

    // a closed bin restarts the sample count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && flush_now) |=> (cnt_reg == '0))
        else $error("sample count not cleared on bin close");

endmodule
